/* sv/rc4_pkg.sv */
package rc4_pkg;

    // table geometry
    localparam int TABLE_SIZE = 256;
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    // command codes on the input word
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // input word
    typedef struct packed {
        logic       command;
        logic [7:0] value;
        logic       last;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD_K,
        ST_KS_RD_J,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_GEN_RD_J,
        ST_GEN_SWAP,
        ST_GEN_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic key_write;
        logic key_start;
        logic ks_rd_k;
        logic ks_rd_j;
        logic ks_wr_k;
        logic ks_wr_j;
        logic gen_start;
        logic gen_rd_j;
        logic gen_swap;
        logic gen_wr_j;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sched_end;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/rc4_ram.sv */
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rc4_ctrl.sv */
module rc4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rc4_pkg::in_word_t   in_data,
    input  rc4_pkg::dp_status_t status,
    output logic                in_ready,
    output rc4_pkg::dp_cmd_t    cmd
);

    rc4_pkg::state_t state_reg;
    rc4_pkg::state_t state_next;
    logic            take;

    assign take = in_valid && (state_reg == rc4_pkg::ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == rc4_pkg::CMD_DATA)
                    begin
                        state_next = rc4_pkg::ST_GEN_RD_J;
                    end
                    else if (in_data.last)
                    begin
                        state_next = rc4_pkg::ST_KS_RD_K;
                    end
                end
            end
            rc4_pkg::ST_KS_RD_K:  state_next = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J:  state_next = rc4_pkg::ST_KS_WR_K;
            rc4_pkg::ST_KS_WR_K:  state_next = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J:
            begin
                state_next = status.sched_end ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD_K;
            end
            rc4_pkg::ST_GEN_RD_J: state_next = rc4_pkg::ST_GEN_SWAP;
            rc4_pkg::ST_GEN_SWAP: state_next = rc4_pkg::ST_GEN_DONE;
            rc4_pkg::ST_GEN_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default:              state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.key_write = take && (in_data.command == rc4_pkg::CMD_KEY);
                cmd.key_start = take && (in_data.command == rc4_pkg::CMD_KEY) && in_data.last;
                cmd.gen_start = take && (in_data.command == rc4_pkg::CMD_DATA);
            end
            rc4_pkg::ST_KS_RD_K:  cmd.ks_rd_k  = 1'b1;
            rc4_pkg::ST_KS_RD_J:  cmd.ks_rd_j  = 1'b1;
            rc4_pkg::ST_KS_WR_K:  cmd.ks_wr_k  = 1'b1;
            rc4_pkg::ST_KS_WR_J:  cmd.ks_wr_j  = 1'b1;
            rc4_pkg::ST_GEN_RD_J: cmd.gen_rd_j = 1'b1;
            rc4_pkg::ST_GEN_SWAP: cmd.gen_swap = 1'b1;
            rc4_pkg::ST_GEN_DONE:
            begin
                cmd.gen_wr_j = 1'b1;
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/rc4_dp.sv */
module rc4_dp #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rc4_pkg::in_word_t   in_data,
    input  rc4_pkg::dp_cmd_t    cmd,
    input  logic                out_ready,
    output rc4_pkg::dp_status_t status,
    output logic                out_valid,
    output rc4_pkg::out_word_t  out_data
);

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW  = $clog2(KEY_DEPTH + 1);

    // index and key bookkeeping
    logic [7:0]     index_i_reg;
    logic [7:0]     index_i_next;
    logic [7:0]     index_j_reg;
    logic [7:0]     index_j_next;
    logic [CW-1:0]  key_count_reg;
    logic [CW-1:0]  key_count_next;
    logic [CW-1:0]  key_len_reg;
    logic [CW-1:0]  key_len_next;
    logic [KAW-1:0] key_idx_reg;
    logic [KAW-1:0] key_idx_next;

    // permutation entries that hold a written value
    logic [rc4_pkg::TABLE_SIZE-1:0] perm_valid_reg;
    logic [rc4_pkg::TABLE_SIZE-1:0] perm_valid_next;
    logic [7:0]                     rd_addr_reg;
    logic                           rd_valid_reg;

    // swap operands and message word
    logic [7:0] s_i_reg;
    logic [7:0] s_i_next;
    logic [7:0] s_j_reg;
    logic [7:0] s_j_next;
    logic [7:0] t_reg;
    logic [7:0] t_next;
    logic [7:0] msg_value_reg;
    logic [7:0] msg_value_next;
    logic       msg_last_reg;
    logic       msg_last_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    rc4_pkg::out_word_t out_data_reg;
    rc4_pkg::out_word_t out_data_next;

    // memory ports
    logic       perm_we;
    logic [7:0] perm_waddr;
    logic [7:0] perm_wdata;
    logic       perm_re;
    logic [7:0] perm_raddr;
    logic [7:0] perm_ram_q;
    logic [7:0] perm_q;
    logic       key_we;
    logic       key_re;
    logic [7:0] key_q;
    logic       key_room;
    logic [CW-1:0] key_count_inc;
    logic [CW-1:0] key_idx_inc;
    logic [7:0] ks;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::TABLE_SIZE)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_ram_q)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_count_reg[KAW-1:0]),
        .wdata (in_data.value),
        .re    (key_re),
        .raddr (key_idx_reg),
        .rdata (key_q)
    );

    // an unwritten entry reads as its own index
    assign perm_q = rd_valid_reg ? perm_ram_q : rd_addr_reg;

    assign key_room      = key_count_reg < CW'(KEY_DEPTH);
    assign key_count_inc = key_count_reg + CW'(1);
    assign key_idx_inc   = CW'(key_idx_reg) + CW'(1);
    assign key_we        = cmd.key_write && key_room;
    assign key_re        = cmd.ks_rd_k;

    // keystream byte, forwarding the two entries just swapped
    always_comb
    begin
        if (t_reg == index_j_reg)
        begin
            ks = s_i_reg;
        end
        else if (t_reg == index_i_reg)
        begin
            ks = s_j_reg;
        end
        else
        begin
            ks = perm_q;
        end
    end

    // permutation memory access
    always_comb
    begin
        perm_we    = 1'b0;
        perm_waddr = index_i_reg;
        perm_wdata = perm_q;
        perm_re    = 1'b0;
        perm_raddr = index_i_reg;
        if (cmd.gen_start)
        begin
            perm_re    = 1'b1;
            perm_raddr = index_i_reg + 8'd1;
        end
        if (cmd.ks_rd_k)
        begin
            perm_re    = 1'b1;
            perm_raddr = index_i_reg;
        end
        if (cmd.ks_rd_j)
        begin
            perm_re    = 1'b1;
            perm_raddr = index_j_reg + perm_q + key_q;
        end
        if (cmd.ks_wr_k)
        begin
            perm_we    = 1'b1;
            perm_waddr = index_i_reg;
            perm_wdata = perm_q;
        end
        if (cmd.ks_wr_j || cmd.gen_wr_j)
        begin
            perm_we    = 1'b1;
            perm_waddr = index_j_reg;
            perm_wdata = s_i_reg;
        end
        if (cmd.gen_rd_j)
        begin
            perm_re    = 1'b1;
            perm_raddr = index_j_reg + perm_q;
        end
        if (cmd.gen_swap)
        begin
            perm_we    = 1'b1;
            perm_waddr = index_i_reg;
            perm_wdata = perm_q;
            perm_re    = 1'b1;
            perm_raddr = s_i_reg + perm_q;
        end
    end

    // next values of state and operands
    always_comb
    begin
        index_i_next    = index_i_reg;
        index_j_next    = index_j_reg;
        key_count_next  = key_count_reg;
        key_len_next    = key_len_reg;
        key_idx_next    = key_idx_reg;
        perm_valid_next = perm_valid_reg;
        s_i_next        = s_i_reg;
        s_j_next        = s_j_reg;
        t_next          = t_reg;
        msg_value_next  = msg_value_reg;
        msg_last_next   = msg_last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        // key byte storage
        if (key_we)
        begin
            key_count_next = key_count_inc;
        end
        if (cmd.key_start)
        begin
            key_len_next    = key_room ? key_count_inc : key_count_reg;
            key_count_next  = '0;
            key_idx_next    = '0;
            index_i_next    = '0;
            index_j_next    = '0;
        end

        // key schedule step
        if (cmd.ks_rd_j)
        begin
            s_i_next     = perm_q;
            index_j_next = perm_raddr;
        end
        if (cmd.ks_wr_j)
        begin
            index_i_next = index_i_reg + 8'd1;
            key_idx_next = (key_idx_inc == key_len_reg) ? '0 : key_idx_inc[KAW-1:0];
            if (status.sched_end)
            begin
                index_j_next = '0;
            end
        end

        // output generation
        if (cmd.gen_start)
        begin
            index_i_next   = perm_raddr;
            msg_value_next = in_data.value;
            msg_last_next  = in_data.last;
        end
        if (cmd.gen_rd_j)
        begin
            s_i_next     = perm_q;
            index_j_next = perm_raddr;
        end
        if (cmd.gen_swap)
        begin
            s_j_next = perm_q;
            t_next   = perm_raddr;
        end

        // written-entry flags
        if (cmd.key_start)
        begin
            perm_valid_next = '0;
        end
        else if (perm_we)
        begin
            perm_valid_next[perm_waddr] = 1'b1;
        end

        // output register
        if (cmd.out_load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.data_out = msg_value_reg ^ ks;
            out_data_next.last_out = msg_last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_i_reg    <= '0;
            index_j_reg    <= '0;
            key_count_reg  <= '0;
            key_len_reg    <= '0;
            key_idx_reg    <= '0;
            perm_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            index_i_reg    <= index_i_next;
            index_j_reg    <= index_j_next;
            key_count_reg  <= key_count_next;
            key_len_reg    <= key_len_next;
            key_idx_reg    <= key_idx_next;
            perm_valid_reg <= perm_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (perm_re)
        begin
            rd_addr_reg  <= perm_raddr;
            rd_valid_reg <= perm_valid_reg[perm_raddr];
        end
        s_i_reg       <= s_i_next;
        s_j_reg       <= s_j_next;
        t_reg         <= t_next;
        msg_value_reg <= msg_value_next;
        msg_last_reg  <= msg_last_next;
        out_data_reg  <= out_data_next;
    end

    assign status.sched_end = index_i_reg == rc4_pkg::BYTE_MAX;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

/* sv/rc4_stream_cipher.sv */
// RC4 stream cipher engine
// Input channel in_valid/in_ready carries one word: command, value, last.
// A key word (command key) stores its byte in the key memory;
// bytes beyond KEY_DEPTH are dropped. A key word with last set also starts
// the key schedule: the permutation returns to identity at once (per-entry
// written flags are cleared) and 256 schedule steps follow, each through the
// states read S[i], read S[j], write S[i], write S[j] on the single-read,
// single-write permutation memory, so in_ready is low until the schedule ends.
// A data word (command data) runs the output generation: read S[i], read
// S[j], swap with keystream read, final write. Its result enters the output
// register at the final write, and no new input word is taken before then;
// a key word without last leaves the input ready again in the next cycle.
// Output channel out_valid/out_ready carries data_out and last_out, one
// word per data word, none per key word. The output register lets the next
// input word be taken while a result waits; if the receiver stalls, the
// engine holds in its final step until the register is free.
// Reset clears the indices, the key count and the output valid, and sets
// the permutation to identity; no clearing pass is needed.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rc4_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rc4_pkg::out_word_t out_data
);

    rc4_pkg::dp_cmd_t    cmd;
    rc4_pkg::dp_status_t status;

    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    rc4_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // final key word starts the schedule, which blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.command == rc4_pkg::CMD_KEY) && in_data.last)
        |=> !in_ready)
    else $error("input taken right after final key word");

    // after a plain key word the input is ready again in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.command == rc4_pkg::CMD_KEY) && !in_data.last)
        |=> in_ready)
    else $error("engine busy after plain key word");

    // with the output register empty, a data word yields its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.command == rc4_pkg::CMD_DATA) && !out_valid)
        |-> ##4 out_valid)
    else $error("data word result missing");

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_DEPTH = 256;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 20;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    rc4_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rc4_pkg::out_word_t out_data;

    // cipher state mirror
    logic [7:0]  sbox [rc4_pkg::TABLE_SIZE];
    logic [7:0]  key_mem [KEY_DEPTH];
    int unsigned key_len;
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;

    rc4_pkg::out_word_t expected_bytes [$];
    rc4_pkg::out_word_t front_word;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    rc4_stream_cipher #(
        .KEY_DEPTH (KEY_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // key schedule: identity, then 256 swaps driven by the stored key
    function automatic void rc4_schedule(int unsigned klen);
        logic [7:0] jv;
        logic [7:0] tmp;
        for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++)
            sbox[k] = k[7:0];
        jv = 8'd0;
        for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++)
        begin
            jv = jv + sbox[k] + key_mem[k % klen];
            tmp = sbox[k];
            sbox[k] = sbox[jv];
            sbox[jv] = tmp;
        end
        idx_i = 8'd0;
        idx_j = 8'd0;
    endfunction

    // advance the cipher mirror by one accepted word
    function automatic void rc4_apply(rc4_pkg::in_word_t w);
        logic [7:0]         tmp;
        logic [7:0]         sum;
        rc4_pkg::out_word_t res;
        if (w.command == rc4_pkg::CMD_KEY)
        begin
            if (key_len < KEY_DEPTH)
            begin
                key_mem[key_len] = w.value;
                key_len++;
            end
            if (w.last)
            begin
                rc4_schedule((key_len == 0) ? 1 : key_len);
                key_len = 0;
            end
        end
        else
        begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            tmp = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = tmp;
            sum = sbox[idx_i] + sbox[idx_j];
            res.data_out = w.value ^ sbox[sum];
            res.last_out = w.last;
            expected_bytes.push_back(res);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
                flag_error($sformatf("unexpected word: data_out=%02h last_out=%0b",
                                     out_data.data_out, out_data.last_out));
            else
            begin
                front_word = expected_bytes.pop_front();
                if (out_data.data_out !== front_word.data_out ||
                    out_data.last_out !== front_word.last_out)
                    flag_error($sformatf({"word mismatch: data_out exp %02h got %02h, ",
                                          "last_out exp %0b got %0b"},
                                         front_word.data_out, out_data.data_out,
                                         front_word.last_out, out_data.last_out));
            end
        end
    end

    // send one word, with random idle before it
    task automatic send_fields(input logic cmd, input logic [7:0] val, input logic lst);
        rc4_pkg::in_word_t w;
        w.command = cmd;
        w.value = val;
        w.last = lst;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        rc4_apply(w);
    endtask

    // hold off until every expected word has come back
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // identity permutation straight after reset
    task automatic test_data_before_key();
        send_fields(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'hFF, 1'b1);
        send_fields(rc4_pkg::CMD_DATA, 8'hA5, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'h5A, 1'b1);
    endtask

    // one-byte keys at both extremes
    task automatic test_single_byte_key();
        send_fields(rc4_pkg::CMD_KEY, 8'h00, 1'b1);
        send_fields(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'h3C, 1'b1);
        send_fields(rc4_pkg::CMD_KEY, 8'hFF, 1'b1);
        send_fields(rc4_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'h00, 1'b1);
    endtask

    // data words while key bytes are pending
    task automatic test_data_mid_key();
        send_fields(rc4_pkg::CMD_KEY, 8'h01, 1'b0);
        send_fields(rc4_pkg::CMD_KEY, 8'h80, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'h12, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'hED, 1'b1);
        send_fields(rc4_pkg::CMD_KEY, 8'h7F, 1'b1);
        send_fields(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'hC3, 1'b0);
        send_fields(rc4_pkg::CMD_DATA, 8'hFF, 1'b1);
    endtask

    // key longer than the store; last flag lands on a dropped byte
    task automatic test_long_key();
        for (int k = 0; k < KEY_DEPTH + 2; k++)
            send_fields(rc4_pkg::CMD_KEY, 8'($urandom_range(255)), (k == KEY_DEPTH + 1));
        for (int k = 0; k < 6; k++)
            send_fields(rc4_pkg::CMD_DATA, 8'($urandom_range(255)), (k == 5));
        // full-length key ending exactly at the store depth
        for (int k = 0; k < KEY_DEPTH; k++)
            send_fields(rc4_pkg::CMD_KEY, 8'($urandom_range(255)), (k == KEY_DEPTH - 1));
        send_fields(rc4_pkg::CMD_DATA, 8'($urandom_range(255)), 1'b1);
    endtask

    // random keys and messages under a given idle mix
    task automatic test_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                input int unsigned n_items, input bit with_pause);
        int unsigned sent;
        int unsigned len;
        int unsigned pos;
        int unsigned burst;
        int unsigned msgs;
        bit          noise;
        bit          lst;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        msgs = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(4) == 0)
            begin
                // new key, now and then broken up by data words
                len = ($urandom_range(7) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
                noise = ($urandom_range(3) == 0);
                pos = $urandom_range(len - 1);
                for (int k = 0; k < len; k++)
                begin
                    send_fields(rc4_pkg::CMD_KEY, 8'($urandom_range(255)), (k == len - 1));
                    sent++;
                    if (noise && k == pos && k != len - 1)
                    begin
                        burst = $urandom_range(3, 1);
                        for (int b = 0; b < burst; b++)
                            send_fields(rc4_pkg::CMD_DATA, 8'($urandom_range(255)),
                                        1'($urandom_range(1)));
                        sent += burst;
                    end
                end
            end
            else
            begin
                // message, sometimes without its closing flag
                len = $urandom_range(12, 1);
                for (int k = 0; k < len; k++)
                begin
                    lst = (k == len - 1) ? ($urandom_range(15) != 0) : ($urandom_range(31) == 0);
                    send_fields(rc4_pkg::CMD_DATA, 8'($urandom_range(255)), lst);
                end
                sent += len;
            end
            msgs++;
            if (with_pause && msgs % 8 == 0)
                drain_outputs();
        end
    endtask

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_stall_pct = 73;
        test_data_before_key();
        test_single_byte_key();
        test_data_mid_key();
        test_long_key();

        test_traffic(32, 73, 170, 1'b1);
        test_traffic(73, 32, 170, 1'b0);
        test_traffic(0, 0, 170, 1'b0);

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mirror reset
    initial
    begin
        for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++)
            sbox[k] = k[7:0];
        key_len = 0;
        idx_i = 8'd0;
        idx_j = 8'd0;
    end

endmodule

/* rc4_stream_cipher.f */
sv/rc4_pkg.sv
sv/rc4_ram.sv
sv/rc4_ctrl.sv
sv/rc4_dp.sv
sv/rc4_stream_cipher.sv
tb/testbench.sv
